// ===== sv/epoch_region_allocator_macros.svh =====
// ---------------------------------------------------------------------------
// epoch region allocator assertion macros
// concurrent check wrappers, removable with NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef EPOCH_REGION_ALLOCATOR_MACROS_SVH
`define EPOCH_REGION_ALLOCATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ERA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("era check failed");
`define ERA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("era check failed");
`else
`define ERA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ERA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/era_pkg.sv =====
// ---------------------------------------------------------------------------
// era_pkg
// shared types and constants of the epoch region allocator
// ---------------------------------------------------------------------------
package era_pkg;
	localparam int unsigned SLOTS = 16;
	localparam logic [24:0] HEAP_WORDS = 25'h1000000;
	localparam logic [24:0] MIN_STABLE = 25'd4096;
	localparam logic [15:0] DEFAULT_DIV = 16'd4;
	localparam logic [15:0] MIN_DIV = 16'd2;
	localparam logic [15:0] MAX16 = 16'hFFFF;
	localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
	localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

	typedef enum logic [2:0] {
		OP_INIT    = 3'd0,
		OP_STABLE  = 3'd1,
		OP_NURSERY = 3'd2,
		OP_BEGIN   = 3'd3,
		OP_RESET   = 3'd4,
		OP_REWIND  = 3'd5,
		OP_QUERY   = 3'd6,
		OP_TEST    = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_STABLE_FULL = 2'd1,
		ST_SLICE_FULL  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_EXEC, S_DIV_SE, S_DIV_PER, S_FILL, S_RRD, S_RWB, S_DONE
	} state_t;

	typedef enum logic {
		CFG_DIVISOR = 1'b0,
		CFG_THREADS = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [24:0] end_w;
		logic [24:0] next_w;
		logic [24:0] start_w;
	} slice_t;

	typedef struct packed {
		logic        start;
		logic [24:0] dividend;
		logic [15:0] divisor;
	} div_req_t;
endpackage

// ===== sv/era_div.sv =====
// ---------------------------------------------------------------------------
// era_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module era_div (
	input  logic               clk,
	input  logic               arst_n,
	input  era_pkg::div_req_t  req,
	output logic               done,
	output logic [24:0]        quotient
);
	logic [24:0] quo_q;
	logic [15:0] rem_q;
	logic [15:0] div_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] trial;
	logic        fits;

	assign trial = {rem_q, quo_q[24]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd24) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? 16'(trial - {1'b0, div_q}) : trial[15:0];
			quo_q <= {quo_q[23:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// ===== sv/epoch_region_allocator.sv =====
// request path: allocations, queries and tests pass through S_EXEC and S_DONE before the result is registered
// throughput: one request in flight; the next is taken the cycle after the result has left
// init: two passes through the shared divider and one write per active slot
// outermost reset: per active slot, a read (S_RRD) then a write back (S_RWB) of the slice memory
// arst_n clears control, statistics and slot valid bits; no clearing pass is needed
// ---------------------------------------------------------------------------
// epoch_region_allocator
// stable region and per-thread nursery slices with nested epoch reset
// ---------------------------------------------------------------------------
`include "epoch_region_allocator_macros.svh"
module epoch_region_allocator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// operation[2:0], thread[6:3], alloc_size[31:7], location[55:32]
	input  logic [55:0]   s_tdata,
	output logic          m_tvalid,
	input  logic          m_tready,
	// status[1:0], address[25:2], used_words[50:26], in_stable[51],
	// nesting_depth[67:52], epochs_done[99:68], reclaimed_total[147:100],
	// peak_used[172:148], zero fill[175:173]
	output logic [175:0]  m_tdata,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [15:0]   cfg_data
);
	era_pkg::state_t   state_q, state_nx;
	era_pkg::op_t      op_s1;
	logic [3:0]        thr_s1;
	logic [24:0]       size_s1;
	logic [23:0]       loc_s1;

	logic [15:0]       divisor_q;
	logic [4:0]        threads_q;
	logic [24:0]       stable_end_q, bump_q;
	logic [15:0]       depth_q;
	logic [31:0]       epochs_q;
	logic [47:0]       reclaim_q;
	logic [24:0]       peak_q;
	logic [15:0]       valid_q;

	era_pkg::slice_t   mem [era_pkg::SLOTS];
	era_pkg::slice_t   rd_s1, slc;
	logic              vld_s1;
	logic [3:0]        mem_ra, mem_wa;
	logic              mem_we;
	era_pkg::slice_t   mem_wd;

	era_pkg::status_t  status_q;
	logic [23:0]       addr_q;
	logic [24:0]       qused_q;
	logic              query_q;
	logic [3:0]        idx_q;
	logic [4:0]        n_q, n_cur;
	logic [24:0]       acc_q, per_q, total_q;
	logic              m_valid_q;
	logic [175:0]      m_data_q;

	era_pkg::div_req_t div_req;
	logic              div_done;
	logic [24:0]       div_quo;
	logic [24:0]       se_new;
	logic              last_idx;
	logic [25:0]       n_sum, s_sum;
	logic [24:0]       slc_used, total_nx;
	logic [48:0]       reclaim_sum;

	era_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign n_cur    = (threads_q == 5'd0) ? 5'd1 :
	                  (threads_q > 5'd16) ? 5'd16 : threads_q;
	assign se_new   = (div_quo < era_pkg::MIN_STABLE) ? era_pkg::MIN_STABLE : div_quo;
	assign last_idx = {1'b0, idx_q} == (n_q - 5'd1);
	assign slc      = vld_s1 ? rd_s1 : '0;
	assign n_sum    = {1'b0, slc.next_w} + {1'b0, size_s1};
	assign s_sum    = {1'b0, bump_q} + {1'b0, size_s1};
	assign slc_used = slc.next_w - slc.start_w;
	assign total_nx = total_q + slc_used;
	assign reclaim_sum = {1'b0, reclaim_q} + {24'd0, total_nx};
	assign s_tready = (state_q == era_pkg::S_IDLE) && !m_valid_q;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			era_pkg::S_IDLE:    if (s_tvalid && s_tready) state_nx = era_pkg::S_EXEC;
			era_pkg::S_EXEC: begin
				if (op_s1 == era_pkg::OP_INIT) state_nx = era_pkg::S_DIV_SE;
				else if (op_s1 == era_pkg::OP_RESET && depth_q <= 16'd1)
					state_nx = era_pkg::S_RRD;
				else state_nx = era_pkg::S_DONE;
			end
			era_pkg::S_DIV_SE:  if (div_done) state_nx = era_pkg::S_DIV_PER;
			era_pkg::S_DIV_PER: if (div_done) state_nx = era_pkg::S_FILL;
			era_pkg::S_FILL:    if (last_idx) state_nx = era_pkg::S_DONE;
			era_pkg::S_RRD:     state_nx = era_pkg::S_RWB;
			era_pkg::S_RWB:     state_nx = last_idx ? era_pkg::S_DONE : era_pkg::S_RRD;
			era_pkg::S_DONE:    state_nx = era_pkg::S_IDLE;
			default:            state_nx = era_pkg::S_IDLE;
		endcase
	end

	// memory and divider control
	always_comb begin
		mem_ra  = idx_q;
		mem_we  = 1'b0;
		mem_wa  = idx_q;
		mem_wd  = slc;
		div_req = '0;
		unique case (state_q)
			era_pkg::S_IDLE: mem_ra = s_tdata[6:3];
			era_pkg::S_EXEC: begin
				mem_wa = thr_s1;
				mem_wd.next_w = n_sum[24:0];
				mem_we = (op_s1 == era_pkg::OP_NURSERY) && (n_sum <= {1'b0, slc.end_w});
				if (op_s1 == era_pkg::OP_INIT) begin
					div_req.start    = 1'b1;
					div_req.dividend = era_pkg::HEAP_WORDS;
					div_req.divisor  = (divisor_q < era_pkg::MIN_DIV) ?
					                   era_pkg::DEFAULT_DIV : divisor_q;
				end
			end
			era_pkg::S_DIV_SE: begin
				div_req.start    = div_done;
				div_req.dividend = era_pkg::HEAP_WORDS - se_new;
				div_req.divisor  = {11'd0, n_q};
			end
			era_pkg::S_FILL: begin
				mem_we = 1'b1;
				mem_wd.start_w = acc_q;
				mem_wd.next_w  = acc_q;
				mem_wd.end_w   = last_idx ? era_pkg::HEAP_WORDS : acc_q + per_q;
			end
			era_pkg::S_RWB: begin
				mem_we = vld_s1;
				mem_wd.next_w = slc.start_w;
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_s1 <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= era_pkg::S_IDLE;
			divisor_q    <= era_pkg::DEFAULT_DIV;
			threads_q    <= 5'd1;
			stable_end_q <= '0;
			bump_q       <= 25'd1;
			depth_q      <= '0;
			epochs_q     <= '0;
			reclaim_q    <= '0;
			peak_q       <= '0;
			valid_q      <= '0;
			vld_s1       <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			state_q <= state_nx;
			vld_s1  <= valid_q[mem_ra];
			if (cfg_we) begin
				unique case (cfg_index)
					era_pkg::CFG_DIVISOR: divisor_q <= cfg_data;
					era_pkg::CFG_THREADS: threads_q <= cfg_data[4:0];
					default:              divisor_q <= divisor_q;
				endcase
			end
			if (m_valid_q && m_tready) m_valid_q <= 1'b0;
			unique case (state_q)
				era_pkg::S_EXEC: begin
					case (op_s1)
						era_pkg::OP_INIT: begin
							valid_q   <= '0;
							depth_q   <= '0;
							epochs_q  <= '0;
							reclaim_q <= '0;
							peak_q    <= '0;
							bump_q    <= 25'd1;
						end
						era_pkg::OP_STABLE:
							if (s_sum <= {1'b0, stable_end_q}) bump_q <= s_sum[24:0];
						era_pkg::OP_BEGIN:
							if (depth_q != era_pkg::MAX16) depth_q <= depth_q + 16'd1;
						era_pkg::OP_RESET:
							depth_q <= (depth_q > 16'd1) ? depth_q - 16'd1 : 16'd0;
						era_pkg::OP_REWIND: bump_q <= 25'd1;
						default: bump_q <= bump_q;
					endcase
				end
				era_pkg::S_DIV_SE: if (div_done) stable_end_q <= se_new;
				era_pkg::S_FILL:   valid_q[idx_q] <= 1'b1;
				era_pkg::S_RWB: begin
					if (last_idx) begin
						reclaim_q <= reclaim_sum[48] ? era_pkg::MAX48 : reclaim_sum[47:0];
						if (total_nx > peak_q) peak_q <= total_nx;
						if (epochs_q != era_pkg::MAX32) epochs_q <= epochs_q + 32'd1;
					end
				end
				era_pkg::S_DONE: m_valid_q <= 1'b1;
				default: valid_q <= valid_q;
			endcase
		end
	end

	// payload and sweep registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			era_pkg::S_IDLE: begin
				op_s1    <= era_pkg::op_t'(s_tdata[2:0]);
				thr_s1   <= s_tdata[6:3];
				size_s1  <= s_tdata[31:7];
				loc_s1   <= s_tdata[55:32];
				status_q <= era_pkg::ST_OK;
				addr_q   <= '0;
				query_q  <= 1'b0;
				qused_q  <= '0;
			end
			era_pkg::S_EXEC: begin
				n_q     <= n_cur;
				idx_q   <= '0;
				total_q <= '0;
				case (op_s1)
					era_pkg::OP_STABLE:
						if (s_sum <= {1'b0, stable_end_q}) addr_q <= bump_q[23:0];
						else status_q <= era_pkg::ST_STABLE_FULL;
					era_pkg::OP_NURSERY:
						if (n_sum <= {1'b0, slc.end_w}) addr_q <= slc.next_w[23:0];
						else status_q <= era_pkg::ST_SLICE_FULL;
					era_pkg::OP_QUERY: begin
						query_q <= 1'b1;
						qused_q <= slc_used;
					end
					default: addr_q <= addr_q;
				endcase
			end
			era_pkg::S_DIV_PER: begin
				per_q <= div_quo;
				acc_q <= stable_end_q;
			end
			era_pkg::S_FILL: begin
				acc_q <= acc_q + per_q;
				idx_q <= idx_q + 4'd1;
			end
			era_pkg::S_RWB: begin
				total_q <= total_nx;
				idx_q   <= idx_q + 4'd1;
			end
			era_pkg::S_DONE: begin
				m_data_q <= {3'd0, peak_q, reclaim_q, epochs_q, depth_q,
				             (loc_s1 != 24'd0) && ({1'b0, loc_s1} < stable_end_q),
				             query_q ? qused_q : bump_q - 25'd1,
				             addr_q, status_q};
			end
			default: idx_q <= idx_q;
		endcase
	end

	`ERA_ASSERT_NEXT(a_accept_exec, clk, arst_n, s_tvalid && s_tready, state_q == era_pkg::S_EXEC)
	`ERA_ASSERT_NOW(a_ready_no_result, clk, arst_n, s_tready, !m_tvalid)
	`ERA_ASSERT_NOW(a_div_in_init, clk, arst_n, div_done, state_q == era_pkg::S_DIV_SE || state_q == era_pkg::S_DIV_PER)
endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// epoch region allocator testbench
// a directed request table followed by random request streams; every result
// is checked field by field against an in-bench allocator predictor, with
// random idling on both streams and one long hold-off on the result side
// ---------------------------------------------------------------------------
module testbench;
	typedef struct packed {
		logic [23:0]   location;
		logic [24:0]   alloc_size;
		logic [3:0]    thread;
		era_pkg::op_t  operation;
	} request_t;

	typedef struct packed {
		logic [2:0]       fill;
		logic [24:0]      peak_used;
		logic [47:0]      reclaimed_total;
		logic [31:0]      epochs_done;
		logic [15:0]      nesting_depth;
		logic             in_stable;
		logic [24:0]      used_words;
		logic [23:0]      address;
		era_pkg::status_t status;
	} grant_t;

	typedef struct {
		request_t req;
		logic     known;
		grant_t   res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [55:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [175:0] m_tdata;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;

	epoch_region_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [15:0] divisor_reg;
	logic [4:0]  threads_reg;
	logic [24:0] stable_end, stable_bump;
	logic [24:0] sl_start [era_pkg::SLOTS];
	logic [24:0] sl_next [era_pkg::SLOTS];
	logic [24:0] sl_end [era_pkg::SLOTS];
	logic [15:0] depth;
	logic [31:0] epochs;
	logic [47:0] reclaimed;
	logic [24:0] peak;

	grant_t expected_grants [$];
	int errors = 0;
	int cycles = 0;
	bit quiet = 0;
	bit hold_off = 0;

	function automatic int active_slots();
		int n;
		n = threads_reg;
		if (n < 1) n = 1;
		if (n > era_pkg::SLOTS) n = era_pkg::SLOTS;
		return n;
	endfunction

	function automatic grant_t allocate(request_t r);
		grant_t g;
		longint unsigned dv, per, tot, sz, used;
		int n;
		bit q;
		g = '0;
		q = 0;
		used = 0;
		sz = r.alloc_size;
		case (r.operation)
			era_pkg::OP_INIT: begin
				n = active_slots();
				dv = divisor_reg;
				if (dv < 2) dv = 4;
				dv = 64'd16777216 / dv;
				if (dv < 4096) dv = 4096;
				stable_end = 25'(dv);
				stable_bump = 25'd1;
				per = (64'd16777216 - dv) / n;
				for (int t = 0; t < era_pkg::SLOTS; t++) begin
					if (t < n) begin
						sl_start[t] = 25'(dv + t * per);
						sl_next[t] = sl_start[t];
						sl_end[t] = (t == n - 1) ? 25'h1000000 : 25'(dv + (t + 1) * per);
					end else begin
						sl_start[t] = '0; sl_next[t] = '0; sl_end[t] = '0;
					end
				end
				depth = '0; epochs = '0; reclaimed = '0; peak = '0;
			end
			era_pkg::OP_STABLE: begin
				if (stable_bump + sz <= stable_end) begin
					g.address = stable_bump[23:0];
					stable_bump = 25'(stable_bump + sz);
				end else g.status = era_pkg::ST_STABLE_FULL;
			end
			era_pkg::OP_NURSERY: begin
				if (sl_next[r.thread] + sz <= sl_end[r.thread]) begin
					g.address = sl_next[r.thread][23:0];
					sl_next[r.thread] = 25'(sl_next[r.thread] + sz);
				end else g.status = era_pkg::ST_SLICE_FULL;
			end
			era_pkg::OP_BEGIN: if (depth != era_pkg::MAX16) depth++;
			era_pkg::OP_RESET: begin
				if (depth > 1) depth--;
				else begin
					depth = '0;
					tot = 0;
					n = active_slots();
					for (int t = 0; t < n; t++) begin
						tot += sl_next[t] - sl_start[t];
						sl_next[t] = sl_start[t];
					end
					reclaimed = (era_pkg::MAX48 - reclaimed < tot) ? era_pkg::MAX48 :
					            48'(reclaimed + tot);
					if (tot > 64'h1FFFFFF) tot = 64'h1FFFFFF;
					if (tot > peak) peak = 25'(tot);
					if (epochs != era_pkg::MAX32) epochs++;
				end
			end
			era_pkg::OP_REWIND: stable_bump = 25'd1;
			era_pkg::OP_QUERY: begin
				q = 1;
				used = sl_next[r.thread] - sl_start[r.thread];
			end
			default: ;
		endcase
		if (!q) used = stable_bump - 1;
		g.used_words = 25'(used);
		g.in_stable = (r.location != 0) && (r.location < stable_end);
		g.nesting_depth = depth;
		g.epochs_done = epochs;
		g.reclaimed_total = reclaimed;
		g.peak_used = peak;
		return g;
	endfunction

	task automatic idle_burst();
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
	endtask

	task automatic send(request_t r);
		idle_burst();
		s_tdata <= r;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_grants.push_back(allocate(r));
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_grants.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(era_pkg::cfg_idx_t idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == era_pkg::CFG_DIVISOR) divisor_reg = val;
		else threads_reg = val[4:0];
		@(negedge clk);
	endtask

	function automatic request_t rand_request();
		request_t r;
		int k;
		r.operation = era_pkg::op_t'($urandom_range(0, 7));
		if (r.operation == era_pkg::OP_INIT && $urandom_range(0, 5) != 0)
			r.operation = era_pkg::OP_NURSERY;
		r.thread = 4'($urandom_range(0, 15));
		k = $urandom_range(0, 9);
		if (k < 6) r.alloc_size = 25'($urandom_range(0, 4000));
		else if (k < 8) r.alloc_size = 25'($urandom_range(0, 2000000));
		else r.alloc_size = 25'($urandom());
		r.location = 24'($urandom());
		if ($urandom_range(0, 1)) r.location = r.location >> $urandom_range(0, 23);
		return r;
	endfunction

	// result side: idling, one long hold-off, field compare
	always @(negedge clk) begin
		if (hold_off) m_tready <= 1'b0;
		else if (!quiet && $urandom_range(0, 7) == 0) m_tready <= 1'b0;
		else m_tready <= 1'b1;
	end

	always @(posedge clk) begin
		grant_t got, want;
		cycles <= cycles + 1;
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			if (expected_grants.size() == 0) begin
				$display("%0t unexpected result %h", $time, m_tdata);
				errors++;
			end else begin
				want = expected_grants.pop_front();
				if (got.status !== want.status)
					$display("%0t status exp %0d got %0d", $time, want.status, got.status);
				if (got.address !== want.address)
					$display("%0t address exp %h got %h", $time, want.address, got.address);
				if (got.used_words !== want.used_words)
					$display("%0t used exp %h got %h", $time, want.used_words, got.used_words);
				if (got.in_stable !== want.in_stable)
					$display("%0t in_stable exp %b got %b", $time, want.in_stable, got.in_stable);
				if (got.nesting_depth !== want.nesting_depth)
					$display("%0t depth exp %0d got %0d", $time, want.nesting_depth,
						got.nesting_depth);
				if (got.epochs_done !== want.epochs_done)
					$display("%0t epochs exp %0d got %0d", $time, want.epochs_done,
						got.epochs_done);
				if (got.reclaimed_total !== want.reclaimed_total)
					$display("%0t reclaimed exp %h got %h", $time, want.reclaimed_total,
						got.reclaimed_total);
				if (got.peak_used !== want.peak_used)
					$display("%0t peak exp %h got %h", $time, want.peak_used, got.peak_used);
				if (got[172:0] !== want[172:0]) errors++;
			end
		end
		if (cycles > 400000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	row_t directed [$];

	task automatic add_row(era_pkg::op_t op, int th, int sz, int loc, logic kn = 0,
		grant_t g = '0);
		row_t w;
		w.req.operation = op;
		w.req.thread = 4'(th);
		w.req.alloc_size = 25'(sz);
		w.req.location = 24'(loc);
		w.known = kn;
		w.res = g;
		directed.push_back(w);
	endtask

	initial begin
		grant_t g, p;
		logic [15:0] phase_divs [5] = '{16'd0, 16'd1, 16'd2, 16'd65535, 16'd3};
		logic [15:0] phase_thr [5] = '{16'd1, 16'd16, 16'd0, 16'd31, 16'd5};
		divisor_reg = 16'd4; threads_reg = 5'd1;
		stable_end = '0; stable_bump = 25'd1;
		for (int t = 0; t < era_pkg::SLOTS; t++) begin
			sl_start[t] = '0; sl_next[t] = '0; sl_end[t] = '0;
		end
		depth = '0; epochs = '0; reclaimed = '0; peak = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// before init: stable full, empty slot rules
		g = '0; g.status = era_pkg::ST_STABLE_FULL;
		add_row(era_pkg::OP_STABLE, 0, 1, 0, 1, g);
		g = '0;
		add_row(era_pkg::OP_NURSERY, 3, 0, 0, 1, g);
		g = '0; g.status = era_pkg::ST_SLICE_FULL;
		add_row(era_pkg::OP_NURSERY, 15, 25'h1000000, 24'hFFFFFF, 1, g);
		g = '0;
		add_row(era_pkg::OP_QUERY, 15, 0, 0, 1, g);
		add_row(era_pkg::OP_TEST, 0, 0, 1, 1, g);
		add_row(era_pkg::OP_INIT, 0, 0, 0);
		add_row(era_pkg::OP_TEST, 0, 0, 0);
		add_row(era_pkg::OP_TEST, 0, 0, 24'hFFFFFF);
		add_row(era_pkg::OP_TEST, 0, 0, 1);
		add_row(era_pkg::OP_STABLE, 0, 25'h1000000, 0);
		add_row(era_pkg::OP_STABLE, 0, 100, 0);
		add_row(era_pkg::OP_STABLE, 0, 0, 0);
		add_row(era_pkg::OP_NURSERY, 0, 1000, 0);
		add_row(era_pkg::OP_NURSERY, 1, 5, 0);
		add_row(era_pkg::OP_NURSERY, 0, 25'h1FFFFFF, 0);
		add_row(era_pkg::OP_QUERY, 0, 0, 0);
		add_row(era_pkg::OP_BEGIN, 0, 0, 0);
		add_row(era_pkg::OP_BEGIN, 0, 0, 0);
		add_row(era_pkg::OP_RESET, 0, 0, 0);
		add_row(era_pkg::OP_RESET, 0, 0, 0);
		add_row(era_pkg::OP_RESET, 0, 0, 0);
		add_row(era_pkg::OP_REWIND, 0, 0, 0);
		foreach (directed[i]) begin
			send(directed[i].req);
			if (directed[i].known) begin
				p = expected_grants[expected_grants.size() - 1];
				// typed row must agree with the predictor too
				if (p[172:0] !== directed[i].res[172:0]) begin
					$display("%0t directed row %0d exp %h got %h", $time, i,
						directed[i].res, p);
					errors++;
				end
				expected_grants[expected_grants.size() - 1] = directed[i].res;
			end
		end
		drain();

		// long hold-off with the sender still pushing
		fork
			begin
				hold_off = 1;
				repeat (60) @(negedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 10; i++) send(rand_request());
		join
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			write_reg(era_pkg::CFG_DIVISOR, phase_divs[ph]);
			write_reg(era_pkg::CFG_THREADS, phase_thr[ph]);
			send('{location: 24'd0, alloc_size: 25'd0, thread: 4'd0,
				operation: era_pkg::OP_INIT});
			if (ph == 4) quiet = 1;
			for (int i = 0; i < 85; i++) send(rand_request());
			drain();
		end

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
